// File: design/wdr_pkg.sv
// Shared types, constants and the answer-record byte table for the DNS responder.
// No dependencies; every other design file imports this package.
package wdr_pkg;

  localparam int MAX_DATAGRAM_DEF = 512;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [7:0] FLAGS_HI   = 8'h81;
  localparam logic [7:0] FLAGS_LO   = 8'h80;
  localparam logic [7:0] PTR_HI     = 8'hC0;
  localparam logic [7:0] PTR_OFFSET = 8'h0C;
  localparam logic [7:0] TTL_LO     = 8'h3C;
  localparam logic [7:0] RDLEN_LO   = 8'h04;
  localparam logic [7:0] ONE_BYTE   = 8'h01;

  localparam int           ANS_IDX_W = 4;
  localparam logic [3:0]   ANS_LAST  = 4'd15;

  typedef enum logic [1:0] {
    CMD_ECHO    = 2'd0,
    CMD_DISCARD = 2'd1,
    CMD_ANSWER  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
  } cmd_t;

  // Byte of the 16-byte A record that follows the question.
  function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                             input logic [31:0] addr);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      4'd0:    b = PTR_HI;
      4'd1:    b = PTR_OFFSET;
      4'd3:    b = ONE_BYTE;
      4'd5:    b = ONE_BYTE;
      4'd9:    b = TTL_LO;
      4'd11:   b = RDLEN_LO;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      4'd15:   b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/wildcard_dns_responder_top.sv
// Top level of the wildcard DNS A-record responder: address register, parser,
// command queue and response emitter. Depends on wdr_pkg and the wdr_* modules.
//
// Takes a DNS query one byte word per cycle and streams the response
// cut-through: id echoed, header rewritten to flags 8180 with one question
// and one answer, question echoed, then a 16-byte A record carrying the
// address last written on cfg_wdata, with out_tx_last on its final word. An
// unanswerable query (shorter than the header, zero question count, question
// cut off or a label pointing past MaxDatagram) yields a single word with
// out_tx_discard and out_tx_last set; the receiver drops what it got so far.
// Query bytes are taken at one per cycle while in_ready is high; the response
// word for an accepted byte goes via the command queue and is registered in
// the emitter. The final QCLASS byte expands into 17 output words, its echo and
// the A record; bytes past the question are still taken without filling the
// queue, and in_ready drops whenever the QueueDepth-entry command queue is full.
// Write cfg only while no response is pending.
module wildcard_dns_responder_top import wdr_pkg::*; #(
  parameter int MaxDatagram = MAX_DATAGRAM_DEF,
  parameter int QueueDepth  = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_tx_discard,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] answer_address_r, answer_address_nxt;
  logic        q_not_full, q_push, q_not_empty, q_pop;
  cmd_t        push_cmd, pop_cmd;

  assign answer_address_nxt = cfg_we ? cfg_wdata : answer_address_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      answer_address_r <= '0;
    end else begin
      answer_address_r <= answer_address_nxt;
    end
  end

  wdr_front #(.MaxDatagram(MaxDatagram)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .in_rx_last (in_rx_last),
    .q_ready    (q_not_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  wdr_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (pop_cmd)
  );

  wdr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_cmd          (pop_cmd),
    .q_pop          (q_pop),
    .answer_address (answer_address_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_byte    (out_tx_byte),
    .out_tx_last    (out_tx_last),
    .out_tx_discard (out_tx_discard)
  );

endmodule

// File: design/wdr_front.sv
// Query parser: accepts datagram words, walks header and QNAME labels and
// emits at most one command per word into the queue. Depends on wdr_pkg.
module wdr_front import wdr_pkg::*; #(
  parameter int MaxDatagram = MAX_DATAGRAM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_rx_last,
  input  logic       q_ready,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int PosW = $clog2(MaxDatagram);
  localparam int SumW = ((PosW > 8) ? PosW : 8) + 1;
  localparam logic [PosW-1:0] PosLimit = PosW'(MaxDatagram - 1);
  localparam logic [SumW-1:0] MaxSum   = SumW'(MaxDatagram);
  localparam logic [PosW-1:0] QnameStart = PosW'(12);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_NAME   = 4'b0010,
    PH_TAIL   = 4'b0100,
    PH_IGNORE = 4'b1000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [PosW-1:0] nlo_r, nlo_nxt;
  logic [7:0]      qch_r, qch_nxt;
  logic [2:0]      tail_r, tail_nxt;

  logic            fire, ends, disc, restart, label_hit;
  logic [SumW-1:0] next_label;
  logic [7:0]      hdr_byte;

  assign in_ready   = q_ready;
  assign fire       = in_valid && q_ready;
  assign ends       = in_rx_last || (pos_r >= PosLimit);
  assign label_hit  = (pos_r == nlo_r);
  assign next_label = SumW'(pos_r) + SumW'(in_rx_byte) + SumW'(1);

  always_comb begin
    unique case (pos_r)
      PosW'(0), PosW'(1): hdr_byte = in_rx_byte;
      PosW'(2):           hdr_byte = FLAGS_HI;
      PosW'(3):           hdr_byte = FLAGS_LO;
      PosW'(5), PosW'(7): hdr_byte = ONE_BYTE;
      default:            hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    nlo_nxt   = nlo_r;
    qch_nxt   = qch_r;
    tail_nxt  = tail_r;
    disc      = 1'b0;
    restart   = 1'b0;
    q_push    = 1'b0;
    q_cmd     = '{kind: CMD_ECHO, data: in_rx_byte};
    if (fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (ends) begin
            disc = 1'b1;
          end else if (pos_r == PosW'(5) && qch_r == 8'h00 && in_rx_byte == 8'h00) begin
            disc = 1'b1;
          end else begin
            q_push     = 1'b1;
            q_cmd.data = hdr_byte;
            if (pos_r == PosW'(4)) qch_nxt = in_rx_byte;
            pos_nxt = pos_r + PosW'(1);
            if (pos_r >= PosW'(11)) phase_nxt = PH_NAME;
          end
        end
        PH_NAME: begin
          if (label_hit && in_rx_byte != 8'h00 && next_label >= MaxSum) begin
            disc = 1'b1;
          end else if (ends) begin
            disc = 1'b1;
          end else begin
            q_push  = 1'b1;
            pos_nxt = pos_r + PosW'(1);
            if (label_hit) begin
              if (in_rx_byte == 8'h00) begin
                phase_nxt = PH_TAIL;
                tail_nxt  = 3'd4;
              end else begin
                nlo_nxt = next_label[PosW-1:0];
              end
            end
          end
        end
        PH_TAIL: begin
          if (tail_r == 3'd1) begin
            // final QCLASS byte: hand over the answer burst
            q_push     = 1'b1;
            q_cmd.kind = CMD_ANSWER;
            if (in_rx_last) restart = 1'b1;
            else phase_nxt = PH_IGNORE;
          end else if (ends) begin
            disc = 1'b1;
          end else begin
            q_push   = 1'b1;
            tail_nxt = tail_r - 3'd1;
            pos_nxt  = pos_r + PosW'(1);
          end
        end
        default: begin
          phase_nxt = PH_IGNORE;
          if (in_rx_last) restart = 1'b1;
        end
      endcase
      if (disc) begin
        q_push = 1'b1;
        q_cmd  = '{kind: CMD_DISCARD, data: 8'h00};
        if (in_rx_last) restart = 1'b1;
        else phase_nxt = PH_IGNORE;
      end
      if (restart) begin
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        nlo_nxt   = QnameStart;
        qch_nxt   = 8'h00;
        tail_nxt  = 3'd4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      nlo_r   <= QnameStart;
      qch_r   <= 8'h00;
      tail_r  <= 3'd4;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      nlo_r   <= nlo_nxt;
      qch_r   <= qch_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule

// File: design/wdr_queue.sv
// Short command queue between the parser and the response emitter.
// Depends on wdr_pkg for the command type.
module wdr_queue import wdr_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_cmd
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slot_r [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign not_full  = (cnt_r != CntW'(Depth));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = slot_r[rd_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + PtrW'(1);
    if (do_pop)  rd_nxt = (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + PtrW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CntW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_cmd;
  end

endmodule

// File: design/wdr_back.sv
// Response emitter: turns queued commands into output words and expands the
// answer command into its 16-byte A record. Depends on wdr_pkg.
module wdr_back import wdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  input  logic [31:0] answer_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_tx_discard
);

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 last_r, last_nxt;
  logic                 disc_r, disc_nxt;
  logic                 burst_r, burst_nxt;
  logic [ANS_IDX_W-1:0] idx_r, idx_nxt;
  logic                 slot_free;

  assign slot_free      = !out_valid_r || out_ready;
  assign q_pop          = slot_free && !burst_r && q_valid;
  assign out_valid      = out_valid_r;
  assign out_tx_byte    = byte_r;
  assign out_tx_last    = last_r;
  assign out_tx_discard = disc_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    disc_nxt      = disc_r;
    burst_nxt     = burst_r;
    idx_nxt       = idx_r;
    if (slot_free) begin
      out_valid_nxt = burst_r || q_valid;
      if (burst_r) begin
        byte_nxt = answer_byte(idx_r, answer_address);
        last_nxt = (idx_r == ANS_LAST);
        disc_nxt = 1'b0;
        idx_nxt  = idx_r + ANS_IDX_W'(1);
        if (idx_r == ANS_LAST) burst_nxt = 1'b0;
      end else if (q_valid) begin
        byte_nxt = q_cmd.data;
        unique case (q_cmd.kind)
          CMD_DISCARD: begin
            last_nxt = 1'b1;
            disc_nxt = 1'b1;
          end
          CMD_ANSWER: begin
            // echo the final QCLASS byte, then stream the record
            last_nxt  = 1'b0;
            disc_nxt  = 1'b0;
            burst_nxt = 1'b1;
            idx_nxt   = '0;
          end
          default: begin
            last_nxt = 1'b0;
            disc_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      burst_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      burst_r     <= burst_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    disc_r <= disc_nxt;
  end

endmodule
